[design/etls_pkg.sv]
// ----------------------------------------------------------------------------
// etls_pkg
// Shared types, codes and prefix tables for the Erlang tag line scanner.
// ----------------------------------------------------------------------------
package etls_pkg;

  localparam int CHAR_W = 8;
  localparam int KIND_W = 3;
  localparam int NUM_KINDS = 5;
  localparam int NUM_PREFIXES = 4;
  localparam int PAT_MAX = 10;

  localparam logic [KIND_W-1:0] KIND_DEFINE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RECORD   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TYPE     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CALLBACK = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FUNCTION = 3'd4;

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_DASH   = "-";
  localparam logic [CHAR_W-1:0] CH_COMMA  = ",";
  localparam logic [CHAR_W-1:0] CH_LPAREN = "(";
  localparam logic [CHAR_W-1:0] CH_RPAREN = ")";
  localparam logic [CHAR_W-1:0] CH_SPACE  = " ";

  localparam logic [NUM_PREFIXES-1:0] ALL_PREFIXES = '1;

  localparam logic [CHAR_W-1:0] PAT_TEXT [NUM_PREFIXES][PAT_MAX] = '{
    '{"-", "d", "e", "f", "i", "n", "e", "(", 8'h00, 8'h00},
    '{"-", "r", "e", "c", "o", "r", "d", "(", 8'h00, 8'h00},
    '{"-", "t", "y", "p", "e", " ", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"-", "c", "a", "l", "l", "b", "a", "c", "k", " "}
  };

  localparam logic [3:0] PAT_LEN [NUM_PREFIXES] = '{4'd8, 4'd8, 4'd6, 4'd10};

  // Controller to datapath.
  typedef struct packed {
    logic step;  // accept the current input transaction
    logic rd;    // read the buffer at the emit index
    logic adv;   // move to the next name character
  } etls_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic emit_req;  // the current input ends a tag that is to be sent
    logic last;      // the shown character is the last one of the tag
  } etls_sts_t;

  function automatic logic is_word_char(input logic [CHAR_W-1:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
           (c >= "a" && c <= "z") || (c == "_");
  endfunction

  function automatic logic [CHAR_W-1:0] pattern_char(input logic [1:0] k,
                                                     input logic [3:0] pos);
    logic [CHAR_W-1:0] ch;
    ch = CH_NUL;
    if (pos < 4'(PAT_MAX)) begin
      ch = PAT_TEXT[k][pos];
    end
    return ch;
  endfunction

  function automatic logic [1:0] lowest_set(input logic [NUM_PREFIXES-1:0] v);
    logic [1:0] k;
    k = 2'd0;
    for (int i = NUM_PREFIXES - 1; i >= 0; i--) begin
      if (v[i]) begin
        k = 2'(i);
      end
    end
    return k;
  endfunction

endpackage

[design/erlang_tag_line_scanner_core.sv]
// Order: a transaction that ends a tag is followed by a buffer read, then the
// output of the first name character; each further name character again takes
// a buffer read, then the output, plus any output stall. An input that makes no
// tag leaves the controller idle. Throughput is set by the controller, which
// reads one buffer entry and shows it before it starts the next read.
// Reset (rst_n low, synchronous) clears the line state and enables all kinds.
// ----------------------------------------------------------------------------
// erlang_tag_line_scanner_core
// Scans Erlang source lines and emits define, record, type, callback and
// function tags one name character per output transaction.
// ----------------------------------------------------------------------------
module erlang_tag_line_scanner_core #(
  parameter int NAME_MAX = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [etls_pkg::NUM_KINDS-1:0]         cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [etls_pkg::CHAR_W-1:0]            in_char_code,
  input  logic                                   in_end_of_line,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [etls_pkg::KIND_W-1:0]            out_tag_kind,
  output logic [etls_pkg::CHAR_W-1:0]            out_name_char,
  output logic                                   out_last_char,
  output logic                                   out_truncated
);

  import etls_pkg::*;

  etls_cmd_t cmd;
  etls_sts_t sts;

  etls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  etls_dp #(
    .NAME_MAX (NAME_MAX)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_char_code   (in_char_code),
    .in_end_of_line (in_end_of_line),
    .cmd            (cmd),
    .sts            (sts),
    .out_tag_kind   (out_tag_kind),
    .out_name_char  (out_name_char),
    .out_last_char  (out_last_char),
    .out_truncated  (out_truncated)
  );

endmodule

[design/etls_ram.sv]
// ----------------------------------------------------------------------------
// etls_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module etls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/etls_dp.sv]
// ----------------------------------------------------------------------------
// etls_dp
// Scanner datapath: line scan state, prefix matcher, name buffer and the
// registers that drive out one tag character per transaction.
// ----------------------------------------------------------------------------
module etls_dp #(
  parameter int NAME_MAX = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [etls_pkg::NUM_KINDS-1:0]         cfg_wdata,
  input  logic [etls_pkg::CHAR_W-1:0]            in_char_code,
  input  logic                                   in_end_of_line,
  input  etls_pkg::etls_cmd_t                    cmd,
  output etls_pkg::etls_sts_t                    sts,
  output logic [etls_pkg::KIND_W-1:0]            out_tag_kind,
  output logic [etls_pkg::CHAR_W-1:0]            out_name_char,
  output logic                                   out_last_char,
  output logic                                   out_truncated
);

  import etls_pkg::*;

  localparam int AW    = $clog2(NAME_MAX);
  localparam int LEN_W = $clog2(NAME_MAX + 1);
  localparam int TOT_W = LEN_W + 1;

  typedef enum logic [2:0] {
    PH_START,
    PH_PREFIX,
    PH_COLLECT,
    PH_FNAME,
    PH_FSPACE,
    PH_SKIP
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [3:0]              pos_r, pos_nxt;
  logic [NUM_PREFIXES-1:0] cand_r, cand_nxt, cand_hit;
  logic [LEN_W-1:0]        len_r, len_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [NUM_KINDS-1:0]    en_r;

  logic [KIND_W-1:0]       ekind_r;
  logic [LEN_W-1:0]        elen_r;
  logic [TOT_W-1:0]        etot_r;
  logic                    eovf_r;
  logic [TOT_W-1:0]        idx_r;

  logic                    append;
  logic                    emit;
  logic [KIND_W-1:0]       emit_kind;
  logic [TOT_W-1:0]        emit_total;
  logic                    emit_ok;
  logic [1:0]              mk, hit_k;
  logic                    ram_we;
  logic [CHAR_W-1:0]       ram_q;

  assign mk = lowest_set(cand_r);

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    cand_nxt  = cand_r;
    len_nxt   = len_r;
    ovf_nxt   = ovf_r;
    append    = 1'b0;
    emit      = 1'b0;
    emit_kind = {1'b0, mk};
    cand_hit  = cand_r;
    hit_k     = 2'd0;

    if (in_end_of_line) begin
      emit      = (phase_r == PH_COLLECT);
      phase_nxt = PH_START;
      pos_nxt   = 4'd0;
      cand_nxt  = ALL_PREFIXES;
      len_nxt   = '0;
      ovf_nxt   = 1'b0;
    end else begin
      case (phase_r)
        PH_START: begin
          if (in_char_code == CH_DASH) begin
            cand_nxt  = ALL_PREFIXES;
            pos_nxt   = 4'd1;
            phase_nxt = PH_PREFIX;
          end else if (is_word_char(in_char_code)) begin
            append    = 1'b1;
            phase_nxt = PH_FNAME;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_PREFIX: begin
          for (int k = 0; k < NUM_PREFIXES; k++) begin
            if (cand_r[k] && (in_char_code == CH_NUL || pos_r >= PAT_LEN[k] ||
                pattern_char(2'(k), pos_r) != in_char_code)) begin
              cand_hit[k] = 1'b0;
            end
          end
          hit_k = lowest_set(cand_hit);
          if (cand_hit == '0) begin
            cand_nxt  = cand_hit;
            phase_nxt = PH_SKIP;
          end else if (pos_r + 4'd1 == PAT_LEN[hit_k]) begin
            cand_nxt  = NUM_PREFIXES'(1) << hit_k;
            len_nxt   = '0;
            ovf_nxt   = 1'b0;
            phase_nxt = PH_COLLECT;
          end else begin
            cand_nxt = cand_hit;
            pos_nxt  = pos_r + 4'd1;
          end
        end
        PH_COLLECT: begin
          if (in_char_code == CH_NUL ||
              ((mk == 2'(KIND_DEFINE) || mk == 2'(KIND_RECORD)) &&
               in_char_code == CH_COMMA) ||
              ((mk == 2'(KIND_DEFINE) || mk == 2'(KIND_TYPE)) &&
               in_char_code == CH_LPAREN) ||
              (mk == 2'(KIND_CALLBACK) && in_char_code == CH_RPAREN)) begin
            emit      = 1'b1;
            phase_nxt = PH_SKIP;
          end else begin
            append = 1'b1;
          end
        end
        PH_FNAME, PH_FSPACE: begin
          if (in_char_code == CH_LPAREN) begin
            emit      = 1'b1;
            emit_kind = KIND_FUNCTION;
            phase_nxt = PH_SKIP;
          end else if (in_char_code == CH_SPACE) begin
            append    = 1'b1;
            phase_nxt = PH_FSPACE;
          end else if (phase_r == PH_FNAME && is_word_char(in_char_code)) begin
            append = 1'b1;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
        default: begin
          phase_nxt = PH_SKIP;
        end
      endcase
    end

    // Characters past the buffer are dropped but remembered as a truncation.
    if (append) begin
      if (len_r < LEN_W'(NAME_MAX)) begin
        len_nxt = len_r + LEN_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  assign ram_we     = cmd.step && append && (len_r < LEN_W'(NAME_MAX));
  assign emit_total = TOT_W'(len_r) + ((emit_kind == KIND_CALLBACK) ? TOT_W'(1) : TOT_W'(0));
  assign emit_ok    = emit && (emit_total != '0) && en_r[emit_kind];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      pos_r   <= 4'd0;
      cand_r  <= ALL_PREFIXES;
      len_r   <= '0;
      ovf_r   <= 1'b0;
      en_r    <= '1;
    end else begin
      if (cfg_we) begin
        en_r <= cfg_wdata;
      end
      if (cmd.step) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        cand_r  <= cand_nxt;
        len_r   <= len_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

  // Tag snapshot: the line state may be cleared by the same transaction.
  always_ff @(posedge clk) begin
    if (cmd.step && emit_ok) begin
      ekind_r <= emit_kind;
      elen_r  <= len_r;
      etot_r  <= emit_total;
      eovf_r  <= ovf_r;
      idx_r   <= '0;
    end else if (cmd.adv) begin
      idx_r <= idx_r + TOT_W'(1);
    end
  end

  etls_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (NAME_MAX)
  ) u_name_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (len_r[AW-1:0]),
    .wdata (in_char_code),
    .re    (cmd.rd),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_q)
  );

  assign out_tag_kind  = ekind_r;
  assign out_name_char = (idx_r < TOT_W'(elen_r)) ? ram_q : CH_RPAREN;
  assign out_last_char = (idx_r + TOT_W'(1) == etot_r);
  assign out_truncated = eovf_r;

  assign sts.emit_req = emit_ok;
  assign sts.last     = out_last_char;

endmodule

[design/etls_ctrl.sv]
// ----------------------------------------------------------------------------
// etls_ctrl
// Controller: takes input transactions and sequences buffer reads and
// output transactions while a tag is being sent.
// ----------------------------------------------------------------------------
module etls_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  etls_pkg::etls_sts_t sts,
  output etls_pkg::etls_cmd_t cmd
);

  import etls_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SHOW
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = (state_r == ST_IDLE);
    out_valid = (state_r == ST_SHOW);
    case (state_r)
      ST_IDLE: begin
        cmd.step = in_valid;
        if (in_valid && sts.emit_req) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_ready) begin
          if (sts.last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.adv   = 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for erlang_tag_line_scanner_core. Short directed lines
// and random Erlang-like source lines go in under random input gaps and
// output stalls. A scan model predicts every tag character, and each output
// transaction is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import etls_pkg::*;

  localparam int NAME_MAX = 32;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef enum logic [2:0] {
    LINE_START, PREFIX_MATCH, NAME_COLLECT, FUNC_NAME, FUNC_SPACE, LINE_SKIP
  } scan_phase_t;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              eol;
  } text_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              trunc;
  } tag_char_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [NUM_KINDS-1:0] cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CHAR_W-1:0]    in_char_code = '0;
  logic                 in_end_of_line = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [KIND_W-1:0]    out_tag_kind;
  logic [CHAR_W-1:0]    out_name_char;
  logic                 out_last_char;
  logic                 out_truncated;

  erlang_tag_line_scanner_core #(
    .NAME_MAX(NAME_MAX)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_char_code  (in_char_code),
    .in_end_of_line(in_end_of_line),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_tag_kind  (out_tag_kind),
    .out_name_char (out_name_char),
    .out_last_char (out_last_char),
    .out_truncated (out_truncated)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Lines waiting to be sent and tag characters waiting to come out.
  text_item_t  text_q[$];
  tag_char_t   tag_chars[$];

  int unsigned n_issued = 0;
  int unsigned n_accepted = 0;
  int unsigned n_taken = 0;
  int unsigned n_seen = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned gap_max = 3;
  int unsigned stall_max = 3;
  int unsigned fill_count = 0;
  int unsigned cycle_count = 0;
  int          mismatches = 0;

  // Scanner state as the predictor sees it.
  scan_phase_t             ph = LINE_START;
  logic [3:0]              pfx_pos = '0;
  logic [NUM_PREFIXES-1:0] pfx_cand = ALL_PREFIXES;
  logic [CHAR_W-1:0]       nbuf [NAME_MAX];
  int unsigned             nlen = 0;
  logic                    ovf = 1'b0;
  logic [NUM_KINDS-1:0]    kinds_on = '1;

  function automatic logic ident_char(input logic [CHAR_W-1:0] c);
    return (c inside {["0":"9"], ["A":"Z"], ["a":"z"]}) || c == "_";
  endfunction

  function automatic logic [KIND_W-1:0] first_prefix(input logic [NUM_PREFIXES-1:0] cand);
    for (int k = 0; k < NUM_PREFIXES; k++) begin
      if (cand[k]) return KIND_W'(k);
    end
    return KIND_DEFINE;
  endfunction

  function automatic logic ends_name(input logic [KIND_W-1:0] kind,
                                     input logic [CHAR_W-1:0] c);
    case (kind)
      KIND_DEFINE: return c == CH_COMMA || c == CH_LPAREN;
      KIND_RECORD: return c == CH_COMMA;
      KIND_TYPE:   return c == CH_LPAREN;
      default:     return c == CH_RPAREN;
    endcase
  endfunction

  task automatic keep_char(input logic [CHAR_W-1:0] c);
    if (nlen < NAME_MAX) begin
      nbuf[nlen] = c;
      nlen++;
    end else begin
      ovf = 1'b1;
    end
  endtask

  task automatic send_tag(input logic [KIND_W-1:0] kind);
    int unsigned total;
    tag_char_t   t;
    total = nlen + ((kind == KIND_CALLBACK) ? 1 : 0);
    if (total == 0 || !kinds_on[kind]) return;
    for (int unsigned i = 0; i < total; i++) begin
      t.kind  = kind;
      t.ch    = (i < nlen) ? nbuf[i] : CH_RPAREN;
      t.last  = (i + 1 == total);
      t.trunc = ovf;
      tag_chars.push_back(t);
    end
  endtask

  task automatic scan_step(input logic [CHAR_W-1:0] c, input logic eol);
    logic [KIND_W-1:0] k;
    if (eol) begin
      if (ph == NAME_COLLECT) send_tag(first_prefix(pfx_cand));
      ph = LINE_START;
      pfx_pos = '0;
      pfx_cand = ALL_PREFIXES;
      nlen = 0;
      ovf = 1'b0;
      return;
    end
    case (ph)
      LINE_START: begin
        if (c == CH_DASH) begin
          pfx_cand = ALL_PREFIXES;
          pfx_pos = 4'd1;
          ph = PREFIX_MATCH;
        end else if (ident_char(c)) begin
          keep_char(c);
          ph = FUNC_NAME;
        end else begin
          ph = LINE_SKIP;
        end
      end
      PREFIX_MATCH: begin
        for (int i = 0; i < NUM_PREFIXES; i++) begin
          if (pfx_cand[i] && (c == CH_NUL || pfx_pos >= PAT_LEN[i] ||
                              PAT_TEXT[i][pfx_pos] != c))
            pfx_cand[i] = 1'b0;
        end
        if (pfx_cand == '0) begin
          ph = LINE_SKIP;
        end else begin
          k = first_prefix(pfx_cand);
          if (pfx_pos + 1 == PAT_LEN[k]) begin
            // Prefix complete: only the matched kind stays a candidate.
            pfx_cand = '0;
            pfx_cand[k] = 1'b1;
            nlen = 0;
            ovf = 1'b0;
            ph = NAME_COLLECT;
          end else begin
            pfx_pos = pfx_pos + 4'd1;
          end
        end
      end
      NAME_COLLECT: begin
        k = first_prefix(pfx_cand);
        if (c == CH_NUL || ends_name(k, c)) begin
          send_tag(k);
          ph = LINE_SKIP;
        end else begin
          keep_char(c);
        end
      end
      FUNC_NAME, FUNC_SPACE: begin
        if (c == CH_LPAREN) begin
          send_tag(KIND_FUNCTION);
          ph = LINE_SKIP;
        end else if (c == CH_SPACE) begin
          keep_char(c);
          ph = FUNC_SPACE;
        end else if (ph == FUNC_NAME && ident_char(c)) begin
          keep_char(c);
        end else begin
          ph = LINE_SKIP;
        end
      end
      default: ph = LINE_SKIP;
    endcase
  endtask

  // Prediction on each accepted input transaction, checking on each output one.
  always @(posedge clk) begin : scoreboard
    tag_char_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        scan_step(in_char_code, in_end_of_line);
        n_accepted <= n_accepted + 1;
      end
      if (out_valid && out_ready) begin
        n_taken <= n_taken + 1;
        if (tag_chars.size() == 0) begin
          $error("unexpected tag character 0x%02h", out_name_char);
          mismatches++;
        end else begin
          want = tag_chars.pop_front();
          if (out_tag_kind !== want.kind) begin
            $error("tag_kind: expected %0d, got %0d", want.kind, out_tag_kind);
            mismatches++;
          end
          if (out_name_char !== want.ch) begin
            $error("name_char: expected 0x%02h, got 0x%02h", want.ch, out_name_char);
            mismatches++;
          end
          if (out_last_char !== want.last) begin
            $error("last_char: expected %0b, got %0b", want.last, out_last_char);
            mismatches++;
          end
          if (out_truncated !== want.trunc) begin
            $error("truncated: expected %0b, got %0b", want.trunc, out_truncated);
            mismatches++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin : sender
    text_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || n_accepted == n_issued) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (text_q.size() != 0) begin
        nxt = text_q.pop_front();
        in_valid <= 1'b1;
        in_char_code <= nxt.code;
        in_end_of_line <= nxt.eol;
        n_issued <= n_issued + 1;
        gap_left <= $urandom_range(0, gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : receiver
    int unsigned d;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (n_taken != n_seen) begin
      n_seen <= n_taken;
      d = $urandom_range(0, stall_max);
      stall_left <= d;
      out_ready <= (d == 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [CHAR_W-1:0] ident_pick();
    string set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  // Mostly identifier characters, now and then any nonzero byte.
  function automatic logic [CHAR_W-1:0] name_char();
    if ($urandom_range(0, 3) != 0) return ident_pick();
    return CHAR_W'($urandom_range(1, 255));
  endfunction

  task automatic put_char(input logic [CHAR_W-1:0] c);
    text_q.push_back({c, 1'b0});
    fill_count++;
  endtask

  // The character code of an end-of-line transaction is don't-care.
  task automatic end_line();
    text_q.push_back({CHAR_W'($urandom_range(0, 255)), 1'b1});
    fill_count++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  task automatic junk_tail();
    repeat ($urandom_range(0, 3)) put_char(CHAR_W'($urandom_range(0, 255)));
  endtask

  task automatic random_line();
    int unsigned       pick;
    int unsigned       len;
    logic [KIND_W-1:0] k;
    pick = $urandom_range(0, 99);
    k = KIND_W'($urandom_range(0, NUM_PREFIXES - 1));
    if (pick < 50) begin
      for (int i = 0; i < PAT_LEN[k]; i++) put_char(PAT_TEXT[k][i]);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 8);
      repeat (len) put_char(name_char());
      case ($urandom_range(0, 3))
        0: ;
        1: put_char(CH_NUL);
        default: begin
          case (k)
            KIND_DEFINE: put_char($urandom_range(0, 1) ? CH_COMMA : CH_LPAREN);
            KIND_RECORD: put_char(CH_COMMA);
            KIND_TYPE:   put_char(CH_LPAREN);
            default:     put_char(CH_RPAREN);
          endcase
        end
      endcase
      junk_tail();
    end else if (pick < 80) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
      repeat (len) put_char(ident_pick());
      repeat ($urandom_range(0, 2)) put_char(CH_SPACE);
      if ($urandom_range(0, 4) != 0) put_char(CH_LPAREN);
      else put_char(name_char());
      junk_tail();
    end else if (pick < 90) begin
      len = $urandom_range(1, PAT_LEN[k] - 1);
      for (int i = 0; i < len; i++) put_char(PAT_TEXT[k][i]);
      if ($urandom_range(0, 1)) put_char(CHAR_W'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 4) == 0) end_line();
        else put_char(CHAR_W'($urandom_range(0, 255)));
      end
    end
    end_line();
  endtask

  task automatic write_kinds(input logic [NUM_KINDS-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    kinds_on = v;
  endtask

  // Let everything queued go in and every predicted character come out.
  task automatic drain();
    while (text_q.size() != 0 || in_valid || n_accepted != n_issued ||
           tag_chars.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [NUM_KINDS-1:0] setting;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_kinds('1);
    // Empty callback name still gives ")".
    put_text("-callback ");
    end_line();
    // Function name keeps the space before the parenthesis.
    put_text("f (");
    end_line();
    // A NUL is not a name character, so the pending function name is dropped.
    put_char("a");
    put_char(CH_NUL);
    put_char(CH_LPAREN);
    end_line();
    // Prefix cut short by the end of the line.
    put_text("-ty");
    end_line();
    put_char(8'hFF);
    end_line();
    drain();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       setting = '0;
        1:       setting = '1;
        4:       setting = '1;
        default: setting = NUM_KINDS'($urandom_range(1, 30));
      endcase
      gap_max = (p == 1) ? 0 : 3;
      stall_max = (p == 3) ? 0 : 3;
      write_kinds(setting);
      fill_count = 0;
      while (fill_count < 25) random_line();
      drain();
    end

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
